FILE: rtl/assert_macros.svh
// assertion helpers shared by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define CHK_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// consequence checked in the cycle after the antecedent
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/bfa_pkg.sv
package bfa_pkg;

    localparam int POOL_BLOCKS      = 32;
    localparam int ALIGN_BLOCKS     = 8;
    localparam int MAX_TILE_BLOCKS  = 16;
    localparam int BLOCK_HALF_WORDS = 1024;

    localparam int ENTRIES     = POOL_BLOCKS + 1;
    localparam int LIST_END    = POOL_BLOCKS + 1;
    localparam int ID_W        = 6;
    localparam int START_W     = 5;
    localparam int CNT_W       = 6;
    localparam int SP_W        = $clog2(POOL_BLOCKS + 1);
    localparam int SIDX_W      = $clog2(POOL_BLOCKS);
    localparam int BLOCK_SHIFT = $clog2(BLOCK_HALF_WORDS);
    localparam int NEED_W      = 17 - BLOCK_SHIFT;
    localparam int SUM_W       = NEED_W + 1;

    typedef enum logic [2:0] {
        CMD_ALLOC     = 3'd0,
        CMD_FIND      = 3'd1,
        CMD_ADD_USE   = 3'd2,
        CMD_DROP_USE  = 3'd3,
        CMD_RECLAIM   = 3'd4,
        CMD_FRAME_END = 3'd5
    } cmd_code_t;

    typedef enum logic [1:0] {
        SEG_FREE = 2'd0,
        SEG_USED = 2'd1,
        SEG_PEND = 2'd2
    } seg_state_t;

    typedef enum logic [1:0] {
        RES_OK        = 2'd0,
        RES_NOT_FOUND = 2'd1,
        RES_NO_SPACE  = 2'd2,
        RES_REFUSED   = 2'd3
    } res_code_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        kind;
        logic [31:0] data_key;
        logic [15:0] size_half_words;
        logic [5:0]  item_id;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  result_id;
        logic [4:0]  start_block;
        logic [5:0]  block_count;
        logic [15:0] use_count;
        logic [5:0]  free_blocks;
        logic [5:0]  pending_blocks;
    } out_item_t;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [CNT_W-1:0]   blocks;
        seg_state_t         state;
        logic               kind;
        logic [31:0]        key;
        logic [15:0]        uses;
        logic [ID_W-1:0]    link;
    } seg_rec_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SET_CODE,
        OP_FRAME_END,
        OP_WALK_INIT,
        OP_WALK_STEP,
        OP_SPLIT_INIT,
        OP_SPLIT_WRITE,
        OP_FIND_UPD,
        OP_ITEM_READ,
        OP_ITEM_UPD,
        OP_RC_INIT,
        OP_RC_EVAL,
        OP_RC_FWD_CHK,
        OP_RC_ABSORB,
        OP_RC_BACK_BP,
        OP_RC_BACK_P,
        OP_RC_WRITE_IT,
        OP_RC_RETRY,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t    op;
        res_code_t code;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cmd_alloc;
        logic cmd_find;
        logic cmd_add_drop;
        logic cmd_reclaim;
        logic cmd_frame_end;
        logic req_bad;
        logic key_zero;
        logic item_bad;
        logic pending_zero;
        logic walk_last;
        logic found;
        logic delay;
        logic fit_ok;
        logic need_ok;
        logic can_retry;
        logic rc_pend;
        logic rec_next_end;
        logic cur_next_end;
        logic n_used;
        logic back_ok;
        logic split_last;
    } dp_stat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_WALK_INIT,
        S_WALK,
        S_WALK_END,
        S_SPLIT_INIT,
        S_SPLIT,
        S_FIND_UPD,
        S_ITEM_RD,
        S_ITEM_UPD,
        S_RC_INIT,
        S_RC_EVAL,
        S_RC_FWD,
        S_RC_FWD_EV,
        S_RC_BACK,
        S_RC_BACK_P,
        S_RC_IT,
        S_RC_END,
        S_FIN
    } fsm_state_t;

endpackage

FILE: rtl/video_block_best_fit_allocator.sv
// Best-fit allocator for a pool of video memory blocks, kept as an ordered linked list of
// segment entries in a single-port-read table. One request beat is taken at a time and
// answered with one response beat; the next request is accepted while the previous
// response still waits. Timing is set by the list walks, one entry per cycle on the table
// read port: find, allocate and reclaim walk the list, and an allocation that reclaims on
// demand adds a reclaim and a second walk. No clearing pass is needed after reset.
module video_block_best_fit_allocator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  bfa_pkg::in_item_t  req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output bfa_pkg::out_item_t rsp
);
    import bfa_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    bfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bfa_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

FILE: rtl/bfa_dp.sv
module bfa_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  bfa_pkg::ctrl_cmd_t  cmd,
    input  bfa_pkg::in_item_t   req,
    output bfa_pkg::dp_stat_t   stat,
    output bfa_pkg::out_item_t  rsp
);
    import bfa_pkg::*;

    localparam logic [ID_W-1:0] END_ID = ID_W'(LIST_END);

    function automatic seg_rec_t clear_rec();
        seg_rec_t r;
        r.start  = '0;
        r.blocks = '0;
        r.state  = SEG_FREE;
        r.kind   = 1'b0;
        r.key    = '0;
        r.uses   = '0;
        r.link   = END_ID;
        return r;
    endfunction

    // contents of an entry that was never written since reset
    function automatic seg_rec_t reset_rec(input logic [ID_W-1:0] id);
        seg_rec_t r;
        r = clear_rec();
        if (id == '0)
        begin
            r.link = ID_W'(1);
        end
        if (id == ID_W'(1))
        begin
            r.blocks = CNT_W'(POOL_BLOCKS);
        end
        return r;
    endfunction

    // segment table
    seg_rec_t           seg_mem [ENTRIES];
    logic [ENTRIES-1:0] vld_reg;
    seg_rec_t           rd_reg;
    logic               rd_vld_reg;
    logic [ID_W-1:0]    raddr_reg;
    seg_rec_t           rec;

    logic            re;
    logic [ID_W-1:0] ra;
    logic            we;
    logic [ID_W-1:0] wa;
    seg_rec_t        wd;

    // spare entry stack
    logic [ID_W-1:0]   spare_reg [POOL_BLOCKS];
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic              push_en;
    logic [ID_W-1:0]   push_id;
    logic [SIDX_W-1:0] sp_top;
    logic [ID_W-1:0]   spare_top;

    in_item_t          in_reg, in_next;
    logic [NEED_W-1:0] blk_reg, blk_next;
    res_code_t         code_reg, code_next;
    logic [ID_W-1:0]   res_id_reg, res_id_next;
    logic [START_W-1:0] res_start_reg, res_start_next;
    logic [CNT_W-1:0]  res_blocks_reg, res_blocks_next;
    logic [15:0]       res_uses_reg, res_uses_next;
    logic [CNT_W-1:0]  free_reg, free_next;
    logic [CNT_W-1:0]  pend_reg, pend_next;
    logic              delay_reg, delay_next;
    logic              pass_reg, pass_next;

    logic [ID_W-1:0]    best_id_reg, best_id_next;
    logic [START_W-1:0] best_start_reg, best_start_next;
    logic [NEED_W-1:0]  best_size_reg, best_size_next;
    logic [CNT_W-1:0]   best_pad_reg, best_pad_next;
    logic [ID_W-1:0]    best_link_reg, best_link_next;
    logic               found_reg, found_next;
    logic [ID_W-1:0]    found_id_reg, found_id_next;
    seg_rec_t           found_rec_reg, found_rec_next;

    logic [ID_W-1:0]    cur_id_reg, cur_id_next;
    logic [START_W-1:0] cur_start_reg, cur_start_next;
    logic [1:0]         k_reg, k_next;
    seg_rec_t           cur_rec_reg, cur_rec_next;
    logic [ID_W-1:0]    bp_id_reg, bp_id_next;
    seg_rec_t           bp_rec_reg, bp_rec_next;
    logic [ID_W-1:0]    p_id_reg, p_id_next;
    seg_rec_t           p_rec_reg, p_rec_next;
    out_item_t          out_reg, out_next;

    // best-fit evaluation of the entry on the read port
    logic [START_W-1:0] wk_extra;
    logic [SUM_W-1:0]   wk_sum;
    logic [CNT_W-1:0]   wk_pad;
    logic               wk_fit;
    logic               wk_match;

    // split pieces
    logic [NEED_W-1:0] rem;
    logic [NEED_W-1:0] len0, len2, len_k;
    logic [1:0]        need_cnt;
    logic              last_piece;

    seg_rec_t  upd;
    logic [CNT_W-1:0] blk_n;

    assign rec = rd_vld_reg ? rd_reg : reset_rec(raddr_reg);

    assign wk_extra = rec.start & START_W'(ALIGN_BLOCKS - 1);
    assign wk_sum   = SUM_W'(blk_reg) + SUM_W'(wk_extra);
    assign wk_pad   = (!in_reg.kind && wk_sum > SUM_W'(MAX_TILE_BLOCKS))
                    ? CNT_W'(ALIGN_BLOCKS) - CNT_W'(wk_extra) : '0;
    assign wk_fit   = (rec.state == SEG_FREE)
                    && (SUM_W'(rec.blocks) >= SUM_W'(blk_reg) + SUM_W'(wk_pad))
                    && (NEED_W'(rec.blocks) < best_size_reg);
    assign wk_match = (rec.state != SEG_FREE) && (rec.key == in_reg.data_key)
                    && (in_reg.data_key != '0);

    assign rem      = best_size_reg - NEED_W'(best_pad_reg) - blk_reg;
    assign len0     = in_reg.kind ? rem : NEED_W'(best_pad_reg);
    assign len2     = in_reg.kind ? '0 : rem;
    assign need_cnt = 2'((best_pad_reg != '0) && !in_reg.kind) + 2'(rem != '0);
    assign last_piece = (k_reg == 2'd2) || ((k_reg == 2'd1) && (len2 == '0));

    always_comb
    begin
        unique case (k_reg)
            2'd0:    len_k = len0;
            2'd1:    len_k = blk_reg;
            default: len_k = len2;
        endcase
    end

    assign blk_n     = CNT_W'(blk_reg);
    assign sp_top    = SIDX_W'(sp_reg - SP_W'(1));
    assign spare_top = spare_reg[sp_top];

    always_comb
    begin
        in_next         = in_reg;
        blk_next        = blk_reg;
        code_next       = code_reg;
        res_id_next     = res_id_reg;
        res_start_next  = res_start_reg;
        res_blocks_next = res_blocks_reg;
        res_uses_next   = res_uses_reg;
        free_next       = free_reg;
        pend_next       = pend_reg;
        delay_next      = delay_reg;
        pass_next       = pass_reg;
        best_id_next    = best_id_reg;
        best_start_next = best_start_reg;
        best_size_next  = best_size_reg;
        best_pad_next   = best_pad_reg;
        best_link_next  = best_link_reg;
        found_next      = found_reg;
        found_id_next   = found_id_reg;
        found_rec_next  = found_rec_reg;
        cur_id_next     = cur_id_reg;
        cur_start_next  = cur_start_reg;
        k_next          = k_reg;
        cur_rec_next    = cur_rec_reg;
        bp_id_next      = bp_id_reg;
        bp_rec_next     = bp_rec_reg;
        p_id_next       = p_id_reg;
        p_rec_next      = p_rec_reg;
        out_next        = out_reg;
        sp_next         = sp_reg;
        re              = 1'b0;
        ra              = '0;
        we              = 1'b0;
        wa              = '0;
        wd              = clear_rec();
        push_en         = 1'b0;
        push_id         = '0;
        upd             = rec;

        unique case (cmd.op)
            OP_LOAD:
            begin
                in_next         = req;
                blk_next        = NEED_W'((17'(req.size_half_words)
                                  + 17'(BLOCK_HALF_WORDS - 1)) >> BLOCK_SHIFT);
                code_next       = RES_OK;
                res_id_next     = '0;
                res_start_next  = '0;
                res_blocks_next = '0;
                res_uses_next   = '0;
                pass_next       = 1'b0;
            end
            OP_SET_CODE:
            begin
                code_next = cmd.code;
            end
            OP_FRAME_END:
            begin
                delay_next = 1'b0;
            end
            OP_WALK_INIT:
            begin
                best_id_next   = END_ID;
                best_size_next = '1;
                best_pad_next  = '0;
                found_next     = 1'b0;
                re             = 1'b1;
                ra             = '0;
            end
            OP_WALK_STEP:
            begin
                if (wk_fit)
                begin
                    best_id_next    = raddr_reg;
                    best_start_next = rec.start;
                    best_size_next  = NEED_W'(rec.blocks);
                    best_pad_next   = wk_pad;
                    best_link_next  = rec.link;
                end
                if (wk_match)
                begin
                    found_next     = 1'b1;
                    found_id_next  = raddr_reg;
                    found_rec_next = rec;
                end
                if (rec.link != END_ID)
                begin
                    re = 1'b1;
                    ra = rec.link;
                end
            end
            OP_SPLIT_INIT:
            begin
                cur_id_next    = best_id_reg;
                cur_start_next = best_start_reg;
                k_next         = (len0 == '0) ? 2'd1 : 2'd0;
                free_next      = free_reg - blk_n;
            end
            OP_SPLIT_WRITE:
            begin
                we        = 1'b1;
                wa        = cur_id_reg;
                wd        = clear_rec();
                wd.start  = cur_start_reg;
                wd.blocks = CNT_W'(len_k);
                wd.link   = last_piece ? best_link_reg : spare_top;
                if (k_reg == 2'd1)
                begin
                    wd.state        = SEG_USED;
                    wd.kind         = in_reg.kind;
                    wd.key          = in_reg.data_key;
                    wd.uses         = 16'd1;
                    res_id_next     = cur_id_reg;
                    res_start_next  = cur_start_reg;
                    res_blocks_next = blk_n;
                    res_uses_next   = 16'd1;
                end
                if (!last_piece)
                begin
                    cur_id_next = spare_top;
                    sp_next     = sp_reg - SP_W'(1);
                end
                cur_start_next = cur_start_reg + START_W'(len_k);
                k_next         = k_reg + 2'd1;
            end
            OP_FIND_UPD:
            begin
                upd = found_rec_reg;
                if (found_rec_reg.state == SEG_USED)
                begin
                    if (found_rec_reg.uses != 16'hFFFF)
                    begin
                        upd.uses = found_rec_reg.uses + 16'd1;
                    end
                end
                else
                begin
                    upd.uses  = 16'd1;
                    upd.state = SEG_USED;
                    pend_next = pend_reg - found_rec_reg.blocks;
                end
                we              = 1'b1;
                wa              = found_id_reg;
                wd              = upd;
                res_id_next     = found_id_reg;
                res_start_next  = upd.start;
                res_blocks_next = upd.blocks;
                res_uses_next   = upd.uses;
            end
            OP_ITEM_READ:
            begin
                re = 1'b1;
                ra = in_reg.item_id;
            end
            OP_ITEM_UPD:
            begin
                if (rec.state != SEG_USED)
                begin
                    code_next = RES_REFUSED;
                end
                else
                begin
                    if (in_reg.cmd == CMD_ADD_USE)
                    begin
                        if (rec.uses != 16'hFFFF)
                        begin
                            upd.uses = rec.uses + 16'd1;
                        end
                    end
                    else
                    begin
                        upd.uses = rec.uses - 16'd1;
                        if (upd.uses == '0)
                        begin
                            upd.state = SEG_PEND;
                            pend_next = pend_reg + rec.blocks;
                        end
                    end
                    we              = 1'b1;
                    wa              = raddr_reg;
                    wd              = upd;
                    res_id_next     = raddr_reg;
                    res_start_next  = upd.start;
                    res_blocks_next = upd.blocks;
                    res_uses_next   = upd.uses;
                end
            end
            OP_RC_INIT:
            begin
                pend_next = '0;
                bp_id_next = END_ID;
                p_id_next  = END_ID;
                re         = 1'b1;
                ra         = '0;
            end
            OP_RC_EVAL:
            begin
                if (rec.state == SEG_PEND)
                begin
                    cur_id_next        = raddr_reg;
                    cur_rec_next       = rec;
                    cur_rec_next.state = SEG_FREE;
                    cur_rec_next.key   = '0;
                    cur_rec_next.kind  = 1'b0;
                    cur_rec_next.uses  = '0;
                    free_next          = free_reg + rec.blocks;
                end
                else
                begin
                    bp_id_next  = p_id_reg;
                    bp_rec_next = p_rec_reg;
                    p_id_next   = raddr_reg;
                    p_rec_next  = rec;
                    if (rec.link != END_ID)
                    begin
                        re = 1'b1;
                        ra = rec.link;
                    end
                end
            end
            OP_RC_FWD_CHK:
            begin
                if (cur_rec_reg.link != END_ID)
                begin
                    re = 1'b1;
                    ra = cur_rec_reg.link;
                end
            end
            OP_RC_ABSORB:
            begin
                // swallow the unused neighbour after the freed segment
                cur_rec_next.blocks = cur_rec_reg.blocks + rec.blocks;
                cur_rec_next.link   = rec.link;
                if (rec.state == SEG_PEND)
                begin
                    free_next = free_reg + rec.blocks;
                end
                we      = 1'b1;
                wa      = raddr_reg;
                wd      = clear_rec();
                push_en = 1'b1;
                push_id = raddr_reg;
            end
            OP_RC_BACK_BP:
            begin
                cur_rec_next.blocks = cur_rec_reg.blocks + p_rec_reg.blocks;
                cur_rec_next.start  = p_rec_reg.start;
                we      = 1'b1;
                wa      = bp_id_reg;
                wd      = bp_rec_reg;
                wd.link = cur_id_reg;
            end
            OP_RC_BACK_P:
            begin
                we         = 1'b1;
                wa         = p_id_reg;
                wd         = clear_rec();
                push_en    = 1'b1;
                push_id    = p_id_reg;
                p_id_next  = bp_id_reg;
                p_rec_next = bp_rec_reg;
            end
            OP_RC_WRITE_IT:
            begin
                we          = 1'b1;
                wa          = cur_id_reg;
                wd          = cur_rec_reg;
                bp_id_next  = p_id_reg;
                bp_rec_next = p_rec_reg;
                p_id_next   = cur_id_reg;
                p_rec_next  = cur_rec_reg;
                if (cur_rec_reg.link != END_ID)
                begin
                    re = 1'b1;
                    ra = cur_rec_reg.link;
                end
            end
            OP_RC_RETRY:
            begin
                delay_next = 1'b1;
                pass_next  = 1'b1;
            end
            OP_FINISH:
            begin
                out_next.status         = code_reg;
                out_next.result_id      = res_id_reg;
                out_next.start_block    = res_start_reg;
                out_next.block_count    = res_blocks_reg;
                out_next.use_count      = res_uses_reg;
                out_next.free_blocks    = free_reg;
                out_next.pending_blocks = pend_reg;
            end
            default:
            begin
            end
        endcase

        if (push_en && (sp_reg < SP_W'(POOL_BLOCKS)))
        begin
            sp_next = sp_reg + SP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            seg_mem[wa] <= wd;
        end
        if (re)
        begin
            rd_reg <= seg_mem[ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            raddr_reg  <= '0;
            sp_reg     <= SP_W'(POOL_BLOCKS - 1);
            free_reg   <= CNT_W'(POOL_BLOCKS);
            pend_reg   <= '0;
            delay_reg  <= 1'b0;
            for (int i = 0; i < POOL_BLOCKS; i++)
            begin
                spare_reg[i] <= ID_W'(i + 2);
            end
        end
        else
        begin
            if (we)
            begin
                vld_reg[wa] <= 1'b1;
            end
            if (re)
            begin
                rd_vld_reg <= vld_reg[ra];
                raddr_reg  <= ra;
            end
            if (push_en && (sp_reg < SP_W'(POOL_BLOCKS)))
            begin
                spare_reg[SIDX_W'(sp_reg)] <= push_id;
            end
            sp_reg    <= sp_next;
            free_reg  <= free_next;
            pend_reg  <= pend_next;
            delay_reg <= delay_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg          <= in_next;
        blk_reg         <= blk_next;
        code_reg        <= code_next;
        res_id_reg      <= res_id_next;
        res_start_reg   <= res_start_next;
        res_blocks_reg  <= res_blocks_next;
        res_uses_reg    <= res_uses_next;
        pass_reg        <= pass_next;
        best_id_reg     <= best_id_next;
        best_start_reg  <= best_start_next;
        best_size_reg   <= best_size_next;
        best_pad_reg    <= best_pad_next;
        best_link_reg   <= best_link_next;
        found_reg       <= found_next;
        found_id_reg    <= found_id_next;
        found_rec_reg   <= found_rec_next;
        cur_id_reg      <= cur_id_next;
        cur_start_reg   <= cur_start_next;
        k_reg           <= k_next;
        cur_rec_reg     <= cur_rec_next;
        bp_id_reg       <= bp_id_next;
        bp_rec_reg      <= bp_rec_next;
        p_id_reg        <= p_id_next;
        p_rec_reg       <= p_rec_next;
        out_reg         <= out_next;
    end

    assign stat.cmd_alloc     = (in_reg.cmd == CMD_ALLOC);
    assign stat.cmd_find      = (in_reg.cmd == CMD_FIND);
    assign stat.cmd_add_drop  = (in_reg.cmd == CMD_ADD_USE) || (in_reg.cmd == CMD_DROP_USE);
    assign stat.cmd_reclaim   = (in_reg.cmd == CMD_RECLAIM);
    assign stat.cmd_frame_end = (in_reg.cmd == CMD_FRAME_END);
    assign stat.req_bad       = (blk_reg == '0)
                              || (!in_reg.kind && blk_reg > NEED_W'(MAX_TILE_BLOCKS));
    assign stat.key_zero      = (in_reg.data_key == '0);
    assign stat.item_bad      = (in_reg.item_id == '0)
                              || (in_reg.item_id > ID_W'(POOL_BLOCKS));
    assign stat.pending_zero  = (pend_reg == '0);
    assign stat.walk_last     = (rec.link == END_ID);
    assign stat.found         = found_reg;
    assign stat.delay         = delay_reg;
    assign stat.fit_ok        = (best_id_reg != END_ID) && (blk_reg <= NEED_W'(free_reg));
    assign stat.need_ok       = (SP_W'(need_cnt) <= sp_reg);
    assign stat.can_retry     = (in_reg.data_key != '0) && (blk_reg <= NEED_W'(pend_reg))
                              && !pass_reg;
    assign stat.rc_pend       = (rec.state == SEG_PEND);
    assign stat.rec_next_end  = (rec.link == END_ID);
    assign stat.cur_next_end  = (cur_rec_reg.link == END_ID);
    assign stat.n_used        = (rec.state == SEG_USED);
    assign stat.back_ok       = (bp_id_reg != END_ID) && (p_rec_reg.state != SEG_USED);
    assign stat.split_last    = last_piece;

    assign rsp = out_reg;

endmodule

FILE: rtl/bfa_ctrl.sv
module bfa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  bfa_pkg::dp_stat_t  stat,
    output bfa_pkg::ctrl_cmd_t cmd
);
    import bfa_pkg::*;

    fsm_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = OP_NONE;
        cmd.code       = RES_OK;
        out_valid_next = out_valid_reg && !rsp_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FIN;
                priority if (stat.cmd_alloc)
                begin
                    if (stat.req_bad)
                    begin
                        cmd.op   = OP_SET_CODE;
                        cmd.code = RES_REFUSED;
                    end
                    else
                    begin
                        state_next = S_WALK_INIT;
                    end
                end
                else if (stat.cmd_find)
                begin
                    if (stat.key_zero)
                    begin
                        cmd.op   = OP_SET_CODE;
                        cmd.code = RES_NOT_FOUND;
                    end
                    else
                    begin
                        state_next = S_WALK_INIT;
                    end
                end
                else if (stat.cmd_add_drop)
                begin
                    if (stat.item_bad)
                    begin
                        cmd.op   = OP_SET_CODE;
                        cmd.code = RES_REFUSED;
                    end
                    else
                    begin
                        state_next = S_ITEM_RD;
                    end
                end
                else if (stat.cmd_reclaim)
                begin
                    if (!stat.pending_zero)
                    begin
                        state_next = S_RC_INIT;
                    end
                end
                else if (stat.cmd_frame_end)
                begin
                    cmd.op = OP_FRAME_END;
                end
                else
                begin
                    cmd.op   = OP_SET_CODE;
                    cmd.code = RES_REFUSED;
                end
            end
            S_WALK_INIT:
            begin
                cmd.op     = OP_WALK_INIT;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                cmd.op = OP_WALK_STEP;
                if (stat.walk_last)
                begin
                    state_next = S_WALK_END;
                end
            end
            S_WALK_END:
            begin
                state_next = S_FIN;
                if (stat.cmd_find)
                begin
                    if (stat.found)
                    begin
                        state_next = S_FIND_UPD;
                    end
                    else
                    begin
                        cmd.op   = OP_SET_CODE;
                        cmd.code = RES_NOT_FOUND;
                    end
                end
                else
                begin
                    priority if (stat.found || (stat.key_zero && stat.delay))
                    begin
                        cmd.op   = OP_SET_CODE;
                        cmd.code = RES_REFUSED;
                    end
                    else if (stat.fit_ok)
                    begin
                        if (stat.need_ok)
                        begin
                            state_next = S_SPLIT_INIT;
                        end
                        else
                        begin
                            cmd.op   = OP_SET_CODE;
                            cmd.code = RES_NO_SPACE;
                        end
                    end
                    else if (stat.can_retry)
                    begin
                        state_next = S_RC_INIT;
                    end
                    else
                    begin
                        cmd.op   = OP_SET_CODE;
                        cmd.code = RES_NO_SPACE;
                    end
                end
            end
            S_SPLIT_INIT:
            begin
                cmd.op     = OP_SPLIT_INIT;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                cmd.op = OP_SPLIT_WRITE;
                if (stat.split_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIND_UPD:
            begin
                cmd.op     = OP_FIND_UPD;
                state_next = S_FIN;
            end
            S_ITEM_RD:
            begin
                cmd.op     = OP_ITEM_READ;
                state_next = S_ITEM_UPD;
            end
            S_ITEM_UPD:
            begin
                cmd.op     = OP_ITEM_UPD;
                state_next = S_FIN;
            end
            S_RC_INIT:
            begin
                cmd.op     = OP_RC_INIT;
                state_next = S_RC_EVAL;
            end
            S_RC_EVAL:
            begin
                cmd.op = OP_RC_EVAL;
                if (stat.rc_pend)
                begin
                    state_next = S_RC_FWD;
                end
                else if (stat.rec_next_end)
                begin
                    state_next = S_RC_END;
                end
            end
            S_RC_FWD:
            begin
                cmd.op     = OP_RC_FWD_CHK;
                state_next = stat.cur_next_end ? S_RC_BACK : S_RC_FWD_EV;
            end
            S_RC_FWD_EV:
            begin
                if (stat.n_used)
                begin
                    state_next = S_RC_BACK;
                end
                else
                begin
                    cmd.op     = OP_RC_ABSORB;
                    state_next = S_RC_FWD;
                end
            end
            S_RC_BACK:
            begin
                if (stat.back_ok)
                begin
                    cmd.op     = OP_RC_BACK_BP;
                    state_next = S_RC_BACK_P;
                end
                else
                begin
                    state_next = S_RC_IT;
                end
            end
            S_RC_BACK_P:
            begin
                cmd.op     = OP_RC_BACK_P;
                state_next = S_RC_IT;
            end
            S_RC_IT:
            begin
                cmd.op     = OP_RC_WRITE_IT;
                state_next = stat.cur_next_end ? S_RC_END : S_RC_EVAL;
            end
            S_RC_END:
            begin
                if (stat.cmd_alloc)
                begin
                    // on-demand reclaim, then one more placement attempt
                    cmd.op     = OP_RC_RETRY;
                    state_next = S_WALK_INIT;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.op         = OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/bfa_checker.sv
`include "assert_macros.svh"

module bfa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input bfa_pkg::in_item_t  req,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input bfa_pkg::out_item_t rsp
);
    import bfa_pkg::*;

    // one request in flight at a time
    `CHK_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

    // a stalled response beat holds
    `CHK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // failed requests report no segment
    `CHK_IMPL(a_fail_zero, rsp_valid && (rsp.status != RES_OK), (rsp.result_id == '0) && (rsp.block_count == '0) && (rsp.use_count == '0))

    // free and pending blocks never exceed the pool
    `CHK_IMPL(a_pool_bound, rsp_valid, (7'(rsp.free_blocks) + 7'(rsp.pending_blocks)) <= 7'(POOL_BLOCKS))

endmodule

bind video_block_best_fit_allocator bfa_checker u_bfa_checker (.*);
